// ===== src/tmna_pkg.sv =====
// ----------------------------------------------------------------------------
// tmna_pkg
// Shared widths, codes and defaults of the triangle mesh area and normal unit.
// ----------------------------------------------------------------------------
package tmna_pkg;

  // store sizes
  localparam int VERTEX_SLOTS_DEF = 1024;
  localparam int FACE_SLOTS_DEF   = 1024;

  // field and datapath widths
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int COORD_W   = 24;
  localparam int VTX_W     = 3 * COORD_W;
  localparam int FACE_W    = 3 * IDX_W;
  localparam int DIFF_W    = 25;
  localparam int MUL_W     = 26;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CROSS_W   = 51;
  localparam int MAG_W     = 50;
  localparam int HALF_W    = 25;
  localparam int SUMSQ_W   = 102;
  localparam int LEN_W     = 51;
  localparam int UNIT_SH   = 14;
  localparam int NUM_W     = MAG_W + UNIT_SH + 1;
  localparam int QUO_W     = 15;
  localparam int NRM_W     = 16;
  localparam int SUM_W     = 26;
  localparam int AREA_W    = 49;
  localparam int CFG_IDX_W = 2;

  // operation codes
  typedef enum logic [1:0] {
    OP_WR_VTX   = 2'd0,
    OP_WR_FACE  = 2'd1,
    OP_FACE_QRY = 2'd2,
    OP_VTX_QRY  = 2'd3
  } op_e;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT   = 2'd1;

endpackage

// ===== src/tmna_ram.sv =====
// ----------------------------------------------------------------------------
// tmna_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tmna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tmna_sqrt.sv =====
// ----------------------------------------------------------------------------
// tmna_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module tmna_sqrt import tmna_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUMSQ_W-1:0] rad_i,
  output logic               done_o,
  output logic [LEN_W-1:0]   root_o
);

  logic [SUMSQ_W-1:0] rem_q, res_q, bit_q;
  logic [5:0]         cnt_q;
  logic               run_q, done_q;
  logic [SUMSQ_W-1:0] trial;

  assign trial = res_q + bit_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'(LEN_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // digit recurrence
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rad_i;
      res_q <= '0;
      bit_q <= SUMSQ_W'(1) << (SUMSQ_W - 2);
    end else if (run_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[LEN_W-1:0];

endmodule

// ===== src/tmna_div.sv =====
// ----------------------------------------------------------------------------
// tmna_div
// Restoring divider for the normal components, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmna_div import tmna_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [LEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  logic [NUM_W-1:0] rem_q, dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic [3:0]       cnt_q;
  logic             run_q, done_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 4'(QUO_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift-subtract step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, UNIT_SH'(0)};
      quo_q <= '0;
    end else if (run_q) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== src/triangle_mesh_area_and_normals_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_mesh_area_and_normals_unit
// Vertex and face stores with face area, face normal and vertex normal queries.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start_i while busy_o is low. Each item gives one result word
//   on the result ports, marked by done_o for a single cycle; the receiver
//   cannot stall, so the word must be taken in that cycle.
//   Register writes (vertex_count, face_count) use the cfg channel, which is
//   always ready; write it only while the unit is idle.
//   Vertex and face writes and all range errors answer in the cycle after the
//   start. A face query reads the face and vertices from the stores, forms 15
//   products on one shared 26x26 multiplier, then runs a 51-step square root
//   and, if the length is not zero, three 15-step divisions. A vertex query
//   walks all in-use faces, evaluating each face that touches the vertex and
//   skipping the others, then normalizes the sum. One item is in flight at
//   a time.
//   Reset clears both registers and the control; the stores are not cleared
//   and must be written before they are read.
// ----------------------------------------------------------------------------
module triangle_mesh_area_and_normals_unit import tmna_pkg::*; #(
  parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEF,
  parameter int FACE_SLOTS   = FACE_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  operation_i,
  input  logic [IDX_W-1:0]            item_index_i,
  input  logic signed [COORD_W-1:0]   coord_x_i,
  input  logic signed [COORD_W-1:0]   coord_y_i,
  input  logic signed [COORD_W-1:0]   coord_z_i,
  input  logic [IDX_W-1:0]            corner_first_i,
  input  logic [IDX_W-1:0]            corner_second_i,
  input  logic [IDX_W-1:0]            corner_third_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CNT_W-1:0]            cfg_data_i,
  output logic                        done_o,
  output logic [AREA_W-1:0]           area_o,
  output logic signed [NRM_W-1:0]     normal_x_o,
  output logic signed [NRM_W-1:0]     normal_y_o,
  output logic signed [NRM_W-1:0]     normal_z_o,
  output logic                        error_o
);

  localparam int VA = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
  localparam int FA = (FACE_SLOTS > 1) ? $clog2(FACE_SLOTS) : 1;
  localparam logic [17:0] VLIM_MAX = 18'(VERTEX_SLOTS);
  localparam logic [17:0] FLIM_MAX = 18'(FACE_SLOTS);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_FACE   = 9'b000000010,
    ST_VTX    = 9'b000000100,
    ST_CROSS  = 9'b000001000,
    ST_SQUARE = 9'b000010000,
    ST_ROOT   = 9'b000100000,
    ST_DIV    = 9'b001000000,
    ST_NEXT   = 9'b010000000,
    ST_LOAD   = 9'b100000000
  } state_e;

  state_e state_q;
  logic [4:0]  step_q;
  logic [1:0]  comp_q;
  logic        vq_q, fin_q;
  logic [CNT_W-1:0] vcount_q, fcount_q, ptr_q;
  logic [IDX_W-1:0] tgt_q;
  logic [IDX_W-1:0] crn_q [3];
  logic signed [COORD_W-1:0] a_q [3];
  logic signed [DIFF_W-1:0]  u_q [3];
  logic signed [DIFF_W-1:0]  v_q [3];
  logic signed [CROSS_W-1:0] cv_q [3];
  logic signed [NRM_W-1:0]   nrm_q [3];
  logic signed [SUM_W-1:0]   sum_q [3];
  logic [SUMSQ_W-1:0] s_q;
  logic [LEN_W-1:0]   len_q;
  logic signed [PROD_W-1:0] prod_q;

  logic              done_q, err_q;
  logic [AREA_W-1:0] area_q;
  logic signed [NRM_W-1:0] out_n_q [3];

  // limits and range checks
  logic [17:0] vlim, flim;
  logic        accept, idx_v_ok, idx_f_ok, crn_ok;
  op_e         op;

  assign vlim = ({7'd0, vcount_q} < VLIM_MAX) ? {7'd0, vcount_q} : VLIM_MAX;
  assign flim = ({7'd0, fcount_q} < FLIM_MAX) ? {7'd0, fcount_q} : FLIM_MAX;
  assign op       = op_e'(operation_i);
  assign accept   = start_i && (state_q == ST_IDLE);
  assign idx_v_ok = {8'd0, item_index_i} < vlim;
  assign idx_f_ok = {8'd0, item_index_i} < flim;
  assign crn_ok   = ({8'd0, corner_first_i} < vlim) && ({8'd0, corner_second_i} < vlim)
                    && ({8'd0, corner_third_i} < vlim);

  // stores
  logic             vram_we, fram_we;
  logic [VA-1:0]    vram_addr;
  logic [FA-1:0]    fram_addr;
  logic [VTX_W-1:0] vram_rdata;
  logic [FACE_W-1:0] fram_rdata;
  logic [IDX_W-1:0] crn_sel;

  assign vram_we = accept && (op == OP_WR_VTX) && idx_v_ok;
  assign fram_we = accept && (op == OP_WR_FACE) && idx_f_ok && crn_ok;
  assign crn_sel = (step_q == 5'd0) ? crn_q[0] : (step_q == 5'd1) ? crn_q[1] : crn_q[2];
  assign vram_addr = (state_q == ST_IDLE) ? VA'(item_index_i) : VA'(crn_sel);
  assign fram_addr = (state_q == ST_IDLE) ? FA'(item_index_i) : FA'(ptr_q);

  tmna_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_SLOTS), .AW(VA)) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .addr_i  (vram_addr),
    .wdata_i ({coord_x_i, coord_y_i, coord_z_i}),
    .rdata_o (vram_rdata)
  );

  tmna_ram #(.WIDTH(FACE_W), .DEPTH(FACE_SLOTS), .AW(FA)) u_face_ram (
    .clk_i   (clk_i),
    .we_i    (fram_we),
    .addr_i  (fram_addr),
    .wdata_i ({corner_first_i, corner_second_i, corner_third_i}),
    .rdata_o (fram_rdata)
  );

  // read-data views
  logic signed [COORD_W-1:0] rd_v [3];
  logic [IDX_W-1:0]          rd_c [3];
  logic                      hit;

  assign rd_v[0] = vram_rdata[VTX_W-1 -: COORD_W];
  assign rd_v[1] = vram_rdata[2*COORD_W-1 -: COORD_W];
  assign rd_v[2] = vram_rdata[COORD_W-1:0];
  assign rd_c[0] = fram_rdata[FACE_W-1 -: IDX_W];
  assign rd_c[1] = fram_rdata[2*IDX_W-1 -: IDX_W];
  assign rd_c[2] = fram_rdata[IDX_W-1:0];
  assign hit = (rd_c[0] == tgt_q) || (rd_c[1] == tgt_q) || (rd_c[2] == tgt_q);

  // magnitudes of the working vector
  logic [MAG_W-1:0] mag [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = cv_q[i][CROSS_W-1] ? MAG_W'(-cv_q[i]) : MAG_W'(cv_q[i]);
    end
  end

  // square term selection: component and partial product kind
  logic [1:0] sq_c, sq_t;
  always_comb begin
    case (step_q[4:1])
      4'd0:    begin sq_c = 2'd0; sq_t = 2'd0; end
      4'd1:    begin sq_c = 2'd0; sq_t = 2'd1; end
      4'd2:    begin sq_c = 2'd0; sq_t = 2'd2; end
      4'd3:    begin sq_c = 2'd1; sq_t = 2'd0; end
      4'd4:    begin sq_c = 2'd1; sq_t = 2'd1; end
      4'd5:    begin sq_c = 2'd1; sq_t = 2'd2; end
      4'd6:    begin sq_c = 2'd2; sq_t = 2'd0; end
      4'd7:    begin sq_c = 2'd2; sq_t = 2'd1; end
      default: begin sq_c = 2'd2; sq_t = 2'd2; end
    endcase
  end

  // shared multiplier operands
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [HALF_W-1:0] mh, ml;

  assign mh = mag[sq_c][MAG_W-1 -: HALF_W];
  assign ml = mag[sq_c][HALF_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_CROSS) begin
      case (step_q[4:1])
        4'd0:    begin mul_a = MUL_W'(u_q[1]); mul_b = MUL_W'(v_q[2]); end
        4'd1:    begin mul_a = MUL_W'(u_q[2]); mul_b = MUL_W'(v_q[1]); end
        4'd2:    begin mul_a = MUL_W'(u_q[2]); mul_b = MUL_W'(v_q[0]); end
        4'd3:    begin mul_a = MUL_W'(u_q[0]); mul_b = MUL_W'(v_q[2]); end
        4'd4:    begin mul_a = MUL_W'(u_q[0]); mul_b = MUL_W'(v_q[1]); end
        default: begin mul_a = MUL_W'(u_q[1]); mul_b = MUL_W'(v_q[0]); end
      endcase
    end else begin
      case (sq_t)
        2'd0:    begin mul_a = signed'({1'b0, mh}); mul_b = signed'({1'b0, mh}); end
        2'd1:    begin mul_a = signed'({1'b0, mh}); mul_b = signed'({1'b0, ml}); end
        default: begin mul_a = signed'({1'b0, ml}); mul_b = signed'({1'b0, ml}); end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // square accumulation term
  logic [SUMSQ_W-1:0] sq_term;
  always_comb begin
    case (sq_t)
      2'd0:    sq_term = SUMSQ_W'(prod_q[PROD_W-2:0]) << (2 * HALF_W);
      2'd1:    sq_term = SUMSQ_W'(prod_q[PROD_W-2:0]) << (HALF_W + 1);
      default: sq_term = SUMSQ_W'(prod_q[PROD_W-2:0]);
    endcase
  end

  // root and divide units
  logic             root_start, root_done, div_start, div_done;
  logic [LEN_W-1:0] root;
  logic [QUO_W-1:0] quo;
  logic [NUM_W-1:0] div_num;
  logic signed [NRM_W-1:0] quo_s;

  assign root_start = (state_q == ST_ROOT) && (step_q == 5'd0);
  assign div_start  = (state_q == ST_DIV) && (step_q == 5'd0);
  assign div_num    = NUM_W'({mag[comp_q], UNIT_SH'(0)}) + NUM_W'(len_q[LEN_W-1:1]);
  assign quo_s      = signed'({1'b0, quo});

  tmna_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (s_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  tmna_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (len_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
      fcount_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_VERTEX_COUNT: vcount_q <= cfg_data_i;
        CFG_FACE_COUNT:   fcount_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // sequencer
  logic [CNT_W:0] ptr_nx;
  assign ptr_nx = {1'b0, ptr_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      comp_q  <= '0;
      vq_q    <= 1'b0;
      fin_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            vq_q  <= (op == OP_VTX_QRY);
            fin_q <= 1'b0;
            step_q <= '0;
            case (op)
              OP_FACE_QRY: begin
                if (idx_f_ok) state_q <= ST_FACE;
                else done_q <= 1'b1;
              end
              OP_VTX_QRY: begin
                if (!idx_v_ok) done_q <= 1'b1;
                else if (flim == 18'd0) state_q <= ST_LOAD;
                else state_q <= ST_FACE;
              end
              default: done_q <= 1'b1;
            endcase
          end
        end
        ST_FACE: begin
          if (step_q == 5'd0) begin
            step_q <= 5'd1;
          end else begin
            step_q <= '0;
            if (vq_q && !hit) state_q <= ST_NEXT;
            else state_q <= ST_VTX;
          end
        end
        ST_VTX: begin
          if (step_q == 5'd3) begin
            step_q  <= '0;
            state_q <= ST_CROSS;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_CROSS: begin
          if (step_q == 5'd11) begin
            step_q  <= '0;
            state_q <= ST_SQUARE;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_SQUARE: begin
          if (step_q == 5'd17) begin
            step_q  <= '0;
            state_q <= ST_ROOT;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_ROOT: begin
          if (step_q == 5'd0) begin
            step_q <= 5'd1;
          end else if (root_done) begin
            step_q  <= '0;
            comp_q  <= '0;
            state_q <= (root == '0) ? ST_NEXT : ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_q == 5'd0) begin
            step_q <= 5'd1;
          end else if (div_done) begin
            step_q <= '0;
            if (comp_q == 2'd2) state_q <= ST_NEXT;
            else comp_q <= comp_q + 2'd1;
          end
        end
        ST_NEXT: begin
          if (!vq_q || fin_q) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if ({6'd0, ptr_nx} == flim) begin
            state_q <= ST_LOAD;
          end else begin
            step_q  <= '0;
            state_q <= ST_FACE;
          end
        end
        ST_LOAD: begin
          fin_q   <= 1'b1;
          step_q  <= '0;
          state_q <= ST_SQUARE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      ST_IDLE: begin
        tgt_q <= item_index_i;
        ptr_q <= (op == OP_FACE_QRY) ? CNT_W'(item_index_i) : '0;
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= '0;
        end
      end
      ST_FACE: begin
        if (step_q != 5'd0) begin
          for (int i = 0; i < 3; i++) begin
            crn_q[i] <= rd_c[i];
            nrm_q[i] <= '0;
          end
        end
      end
      ST_VTX: begin
        for (int i = 0; i < 3; i++) begin
          if (step_q == 5'd1) a_q[i] <= rd_v[i];
          if (step_q == 5'd2) u_q[i] <= DIFF_W'(rd_v[i]) - DIFF_W'(a_q[i]);
          if (step_q == 5'd3) v_q[i] <= DIFF_W'(rd_v[i]) - DIFF_W'(a_q[i]);
        end
      end
      ST_CROSS: begin
        if (step_q[0]) begin
          if (step_q[1]) cv_q[step_q[3:2]] <= cv_q[step_q[3:2]] - CROSS_W'(prod_q);
          else cv_q[step_q[3:2]] <= CROSS_W'(prod_q);
        end
        s_q <= '0;
      end
      ST_SQUARE: begin
        if (step_q[0]) s_q <= s_q + sq_term;
      end
      ST_ROOT: begin
        if (root_done) begin
          len_q <= root;
          for (int i = 0; i < 3; i++) begin
            nrm_q[i] <= '0;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          nrm_q[comp_q] <= cv_q[comp_q][CROSS_W-1] ? -quo_s : quo_s;
        end
      end
      ST_NEXT: begin
        if (vq_q && !fin_q) begin
          for (int i = 0; i < 3; i++) begin
            sum_q[i] <= sum_q[i] + SUM_W'(nrm_q[i]);
          end
          ptr_q <= ptr_nx[CNT_W-1:0];
        end
      end
      ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          cv_q[i] <= CROSS_W'(sum_q[i]);
        end
        s_q <= '0;
      end
      default: ;
    endcase
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      area_q <= '0;
      err_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        out_n_q[i] <= '0;
      end
      case (op)
        OP_WR_VTX:   err_q <= !idx_v_ok;
        OP_WR_FACE:  err_q <= !(idx_f_ok && crn_ok);
        OP_FACE_QRY: err_q <= !idx_f_ok;
        default:     err_q <= !idx_v_ok;
      endcase
    end else if (state_q == ST_NEXT) begin
      area_q <= vq_q ? '0 : AREA_W'(len_q[LEN_W-1:1]);
      err_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        out_n_q[i] <= nrm_q[i];
      end
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign area_o     = area_q;
  assign normal_x_o = out_n_q[0];
  assign normal_y_o = out_n_q[1];
  assign normal_z_o = out_n_q[2];
  assign error_o    = err_q;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the triangle mesh area and normal unit. A directed
// table covers reset, field extremes, range errors, degenerate faces and stale
// corners, then random phases reprogram the counts and mix well-formed
// vertex/face writes and queries with out-of-range noise. Every result word
// is compared against a bench-side mesh model or a word typed in the table.
// ----------------------------------------------------------------------------
module tb;
  import tmna_pkg::*;

  localparam int SLOTS     = 1024;
  localparam int PHASES    = 16;
  localparam int PHASE_LEN = 125;
  localparam int STALL_MAX = 400000;

  typedef struct {
    op_e                       op;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x, y, z;
    logic [IDX_W-1:0]          c0, c1, c2;
  } mesh_item_t;

  typedef struct {
    logic [AREA_W-1:0]       area;
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic                    err;
  } mesh_result_t;

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    int unsigned          reg_val;
    mesh_item_t           it;
    bit                   typed;
    bit                   typed_err;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] operation_i = '0;
  logic [IDX_W-1:0] item_index_i = '0;
  logic signed [COORD_W-1:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic [IDX_W-1:0] corner_first_i = '0, corner_second_i = '0, corner_third_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CNT_W-1:0] cfg_data_i = '0;
  logic done_o;
  logic [AREA_W-1:0] area_o;
  logic signed [NRM_W-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic error_o;

  triangle_mesh_area_and_normals_unit dut (.*);

  // mesh model state
  int unsigned  vertex_count, face_count;
  longint       vtx_pos[SLOTS][3];
  int unsigned  face_corner[SLOTS][3];
  bit           vtx_set[SLOTS];
  bit           face_set[SLOTS];
  mesh_result_t pending_words[$];
  int           fail_cnt = 0;
  int           idle_pct = 0;
  dir_row_t     directed_rows[$];

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [127:0] mag128(input longint v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic [63:0] root_floor(input logic [127:0] s);
    logic [127:0] r, t;
    r = '0;
    for (int b = 50; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    return r[63:0];
  endfunction

  // q1.14 component, rounded half away from zero
  function automatic logic signed [NRM_W-1:0] unit_comp(input longint c,
                                                        input logic [63:0] len);
    logic [127:0] q;
    if (len == 0) return '0;
    q = (mag128(c) * 128'd16384 + 128'(len / 2)) / 128'(len);
    if (c < 0) return -$signed(q[NRM_W-1:0]);
    return $signed(q[NRM_W-1:0]);
  endfunction

  function automatic void face_eval(input int f, output logic [AREA_W-1:0] area,
                                    output logic signed [NRM_W-1:0] nx, ny, nz);
    longint a[3], u[3], v[3], cr[3];
    logic [127:0] ss;
    logic [63:0] len;
    ss = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = vtx_pos[face_corner[f][0]][i];
      u[i] = vtx_pos[face_corner[f][1]][i] - a[i];
      v[i] = vtx_pos[face_corner[f][2]][i] - a[i];
    end
    cr[0] = u[1] * v[2] - u[2] * v[1];
    cr[1] = u[2] * v[0] - u[0] * v[2];
    cr[2] = u[0] * v[1] - u[1] * v[0];
    for (int i = 0; i < 3; i++) ss += mag128(cr[i]) * mag128(cr[i]);
    len  = root_floor(ss);
    area = AREA_W'(len >> 1);
    nx   = unit_comp(cr[0], len);
    ny   = unit_comp(cr[1], len);
    nz   = unit_comp(cr[2], len);
  endfunction

  // expected word for one accepted item; updates the stores
  function automatic mesh_result_t predict_mesh(input mesh_item_t it);
    mesh_result_t r;
    int unsigned vlim, flim;
    longint s[3];
    logic [127:0] sq;
    logic [63:0] len;
    logic [AREA_W-1:0] fa;
    logic signed [NRM_W-1:0] fx, fy, fz;
    r.area = '0; r.nx = '0; r.ny = '0; r.nz = '0; r.err = 1'b0;
    vlim = vertex_count < SLOTS ? vertex_count : SLOTS;
    flim = face_count < SLOTS ? face_count : SLOTS;
    case (it.op)
      OP_WR_VTX: begin
        if (it.idx >= vlim) r.err = 1'b1;
        else begin
          vtx_pos[it.idx][0] = it.x;
          vtx_pos[it.idx][1] = it.y;
          vtx_pos[it.idx][2] = it.z;
          vtx_set[it.idx] = 1'b1;
        end
      end
      OP_WR_FACE: begin
        if (it.idx >= flim || it.c0 >= vlim || it.c1 >= vlim || it.c2 >= vlim) r.err = 1'b1;
        else begin
          face_corner[it.idx][0] = it.c0;
          face_corner[it.idx][1] = it.c1;
          face_corner[it.idx][2] = it.c2;
          face_set[it.idx] = 1'b1;
        end
      end
      OP_FACE_QRY: begin
        if (it.idx >= flim) r.err = 1'b1;
        else face_eval(it.idx, r.area, r.nx, r.ny, r.nz);
      end
      default: begin
        if (it.idx >= vlim) r.err = 1'b1;
        else begin
          s[0] = 0; s[1] = 0; s[2] = 0;
          for (int f = 0; f < flim; f++) begin
            if (face_corner[f][0] == it.idx || face_corner[f][1] == it.idx ||
                face_corner[f][2] == it.idx) begin
              face_eval(f, fa, fx, fy, fz);
              s[0] += fx; s[1] += fy; s[2] += fz;
            end
          end
          sq = '0;
          for (int i = 0; i < 3; i++) sq += mag128(s[i]) * mag128(s[i]);
          len  = root_floor(sq);
          r.nx = unit_comp(s[0], len);
          r.ny = unit_comp(s[1], len);
          r.nz = unit_comp(s[2], len);
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      1: return COORD_W'($urandom_range(8191)) - 24'sd4096;
      2: return COORD_W'($urandom_range(63)) * 24'sd4096 - 24'sd131072;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // written vertex below the limit, or -1
  function automatic int pick_vertex(input int unsigned vlim);
    int unsigned r;
    if (vlim == 0) return -1;
    r = $urandom_range(vlim - 1);
    for (int unsigned k = 0; k < vlim; k++)
      if (vtx_set[(r + k) % vlim]) return (r + k) % vlim;
    return -1;
  endfunction

  // one random item, mostly well-formed, some out-of-range noise
  function automatic mesh_item_t next_item();
    mesh_item_t it;
    int unsigned vlim, flim, pick, kind;
    int fidx, c;
    vlim = vertex_count < SLOTS ? vertex_count : SLOTS;
    flim = face_count < SLOTS ? face_count : SLOTS;
    it.op = op_e'($urandom_range(3));
    it.idx = $urandom; it.x = $urandom; it.y = $urandom; it.z = $urandom;
    it.c0 = $urandom; it.c1 = $urandom; it.c2 = $urandom;
    fidx = -1;
    pick = $urandom_range(99);
    kind = pick < 30 ? 0 : pick < 55 ? 1 : pick < 80 ? 2 : pick < 92 ? 3 : 4;
    // vertex query only once every face in use is written
    if (kind == 3) begin
      for (int f = 0; f < flim && fidx < 0; f++) if (!face_set[f]) fidx = f;
      if (vlim == 0) kind = 4;
      else if (fidx >= 0) kind = 1;
    end
    if (kind == 2) begin
      if (flim == 0) kind = 4;
      else begin
        fidx = $urandom_range(flim - 1);
        if (!face_set[fidx]) kind = 1;
      end
    end
    if (kind == 1 && (flim == 0 || pick_vertex(vlim) < 0)) kind = 0;
    if (kind == 0 && vlim == 0) kind = 4;
    if (kind == 4 && vlim >= SLOTS && flim >= SLOTS) kind = 0;
    case (kind)
      0: begin
        it.op = OP_WR_VTX; it.idx = $urandom_range(vlim - 1);
        it.x = rand_coord(); it.y = rand_coord(); it.z = rand_coord();
      end
      1: begin
        it.op  = OP_WR_FACE;
        it.idx = fidx >= 0 ? fidx : $urandom_range(flim - 1);
        it.c0  = pick_vertex(vlim);
        it.c1  = pick_vertex(vlim);
        it.c2  = $urandom_range(9) == 0 ? it.c1 : IDX_W'(pick_vertex(vlim));
      end
      2: begin
        it.op = OP_FACE_QRY; it.idx = fidx;
      end
      3: begin
        it.op = OP_VTX_QRY; it.idx = $urandom_range(vlim - 1);
      end
      default: begin
        // out-of-range index or corner
        forever begin
          c = $urandom_range(3);
          if ((c == 0 || c == 3) && vlim < SLOTS) begin
            it.op = c == 0 ? OP_WR_VTX : OP_VTX_QRY;
            it.idx = $urandom_range(SLOTS - 1, vlim);
            break;
          end
          if (c == 1 && vlim < SLOTS) begin
            it.op = OP_WR_FACE;
            case ($urandom_range(2))
              0: it.c0 = $urandom_range(SLOTS - 1, vlim);
              1: it.c1 = $urandom_range(SLOTS - 1, vlim);
              default: it.c2 = $urandom_range(SLOTS - 1, vlim);
            endcase
            break;
          end
          if (c == 2 && flim < SLOTS) begin
            it.op = $urandom_range(1) ? OP_FACE_QRY : OP_WR_FACE;
            it.idx = $urandom_range(SLOTS - 1, flim);
            break;
          end
        end
      end
    endcase
    return it;
  endfunction

  // send one word; lowers start only when a gap is taken
  task automatic issue(input mesh_item_t it, input bit typed, input bit typed_err);
    mesh_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    operation_i     <= it.op;
    item_index_i    <= it.idx;
    coord_x_i       <= it.x;
    coord_y_i       <= it.y;
    coord_z_i       <= it.z;
    corner_first_i  <= it.c0;
    corner_second_i <= it.c1;
    corner_third_i  <= it.c2;
    do @(posedge clk_i); while (busy_o);
    r = predict_mesh(it);
    if (typed) begin
      r.area = '0; r.nx = '0; r.ny = '0; r.nz = '0; r.err = typed_err;
    end
    pending_words.push_back(r);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ri;
    cfg_data_i  <= CNT_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    if (ri == CFG_VERTEX_COUNT) vertex_count = val;
    else if (ri == CFG_FACE_COUNT) face_count = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] ri,
                                       input int unsigned val);
    dir_row_t d;
    d = '{default: 0};
    d.is_reg = 1'b1; d.reg_idx = ri; d.reg_val = val;
    return d;
  endfunction

  function automatic dir_row_t item_row(input op_e op, input int unsigned idx,
                                        input int x, y, z,
                                        input int unsigned c0, c1, c2,
                                        input bit typed, typed_err);
    dir_row_t d;
    d = '{default: 0};
    d.it.op = op; d.it.idx = idx;
    d.it.x = x; d.it.y = y; d.it.z = z;
    d.it.c0 = c0; d.it.c1 = c1; d.it.c2 = c2;
    d.typed = typed; d.typed_err = typed_err;
    return d;
  endfunction

  // result checker and watchdog
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    mesh_result_t e;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("triangle_mesh_area_and_normals_unit regression: fail");
        $finish;
      end
      if (done_o) begin
        if (pending_words.size() == 0) begin
          $error("result word with nothing expected");
          fail_cnt++;
        end else begin
          e = pending_words.pop_front();
          if (area_o !== e.area) begin
            $error("area: expected %0d, got %0d", e.area, area_o); fail_cnt++;
          end
          if (normal_x_o !== e.nx) begin
            $error("normal_x: expected %0d, got %0d", e.nx, normal_x_o); fail_cnt++;
          end
          if (normal_y_o !== e.ny) begin
            $error("normal_y: expected %0d, got %0d", e.ny, normal_y_o); fail_cnt++;
          end
          if (normal_z_o !== e.nz) begin
            $error("normal_z: expected %0d, got %0d", e.nz, normal_z_o); fail_cnt++;
          end
          if (error_o !== e.err) begin
            $error("error: expected %0d, got %0d", e.err, error_o); fail_cnt++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned idle_modes[3];
    idle_modes = '{0, 85, 13};
    vertex_count = 0;
    face_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: reset limits, extremes, degenerate and stale faces
    directed_rows.push_back(item_row(OP_WR_VTX, 0, 1, 2, 3, 0, 0, 0, 1, 1));
    directed_rows.push_back(item_row(OP_FACE_QRY, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    directed_rows.push_back(item_row(OP_VTX_QRY, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    directed_rows.push_back(item_row(OP_WR_FACE, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    directed_rows.push_back(reg_row(CFG_VERTEX_COUNT, 2047));
    directed_rows.push_back(reg_row(CFG_FACE_COUNT, 2047));
    directed_rows.push_back(item_row(OP_WR_VTX, 1023, 8388607, 8388607, 8388607,
                                     0, 0, 0, 1, 0));
    directed_rows.push_back(item_row(OP_WR_VTX, 0, -8388608, -8388608, -8388608,
                                     0, 0, 0, 1, 0));
    directed_rows.push_back(item_row(OP_WR_VTX, 1, 8388607, -8388608, 0, 0, 0, 0, 1, 0));
    directed_rows.push_back(item_row(OP_WR_VTX, 2, -8388608, 0, 8388607, 0, 0, 0, 1, 0));
    directed_rows.push_back(item_row(OP_WR_FACE, 1023, 0, 0, 0, 1023, 0, 1, 1, 0));
    directed_rows.push_back(item_row(OP_WR_FACE, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    directed_rows.push_back(item_row(OP_WR_FACE, 1, 0, 0, 0, 0, 1, 2, 1, 0));
    directed_rows.push_back(item_row(OP_FACE_QRY, 1023, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(item_row(OP_FACE_QRY, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    directed_rows.push_back(item_row(OP_FACE_QRY, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(reg_row(CFG_FACE_COUNT, 2));
    directed_rows.push_back(item_row(OP_VTX_QRY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(item_row(OP_VTX_QRY, 2, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(item_row(OP_VTX_QRY, 512, 0, 0, 0, 0, 0, 0, 1, 0));
    directed_rows.push_back(item_row(OP_FACE_QRY, 2, 0, 0, 0, 0, 0, 0, 1, 1));
    directed_rows.push_back(reg_row(CFG_VERTEX_COUNT, 3));
    directed_rows.push_back(reg_row(CFG_FACE_COUNT, 1024));
    directed_rows.push_back(item_row(OP_FACE_QRY, 1023, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(item_row(OP_WR_FACE, 5, 0, 0, 0, 0, 1, 1023, 1, 1));
    directed_rows.push_back(item_row(OP_WR_VTX, 3, 0, 0, 0, 0, 0, 0, 1, 1));
    directed_rows.push_back(item_row(OP_VTX_QRY, 3, 0, 0, 0, 0, 0, 0, 1, 1));
    directed_rows.push_back(item_row(OP_WR_VTX, 2, 1, 2, 3, 0, 0, 0, 1, 0));
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        drain();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        issue(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].typed_err);
      end
    end

    // random phases over several count settings and idle rates
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        2: begin
          write_reg(CFG_VERTEX_COUNT, 2047); write_reg(CFG_FACE_COUNT, 1024);
        end
        5: begin
          write_reg(CFG_VERTEX_COUNT, 1024); write_reg(CFG_FACE_COUNT, 0);
        end
        9: begin
          write_reg(CFG_VERTEX_COUNT, 0); write_reg(CFG_FACE_COUNT, $urandom_range(1, 8));
        end
        default: begin
          write_reg(CFG_VERTEX_COUNT, $urandom_range(3, 32));
          write_reg(CFG_FACE_COUNT, $urandom_range(1, 12));
        end
      endcase
      idle_pct = idle_modes[ph % 3];
      for (int n = 0; n < PHASE_LEN; n++) issue(next_item(), 1'b0, 1'b0);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) $display("triangle_mesh_area_and_normals_unit regression: pass");
    else $display("triangle_mesh_area_and_normals_unit regression: fail");
    $finish;
  end

endmodule
